// File: rtl/snr_pkg.sv
// snr_pkg: shared types and constants for the image snr estimator
// no dependencies
package snr_pkg;
  localparam int unsigned MaxVoxLog2 = 24;
  localparam int unsigned CntW = MaxVoxLog2 + 1;
  localparam int unsigned SsW = 41;
  localparam int unsigned NsW = 42;
  localparam int unsigned NqW = 58;
  localparam logic [16:0] KRegion = 17'd42926;
  localparam logic [16:0] KDiff = 17'd92682;

  typedef enum logic [2:0] {
    StOk = 3'd0,
    StNoSignal = 3'd1,
    StFewNoise = 3'd2,
    StZeroVar = 3'd3,
    StSat = 3'd4
  } status_e;
endpackage

// File: rtl/image_snr_estimator.sv
// image_snr_estimator: streams voxels into accumulators, one transfer per ready cycle
// result: the last voxel starts a sequence of shift-add multiplies, a 128-step
// restoring divide, a 64-step square root, two more multiplies and a second divide;
// an empty signal region, too few noise samples or zero variance go straight to output
// throughput: one voxel per cycle; input not ready while the result is computed or held
// reset: asynchronous active low, clears accumulators, mode and control state
// depends on snr_pkg and snr_mul
module image_snr_estimator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  pixel_i,
  input  logic signed [15:0]  second_pixel_i,
  input  logic                signal_mask_i,
  input  logic                noise_mask_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  snr_o,
  output logic [2:0]          status_o
);
  import snr_pkg::*;

  typedef enum logic [9:0] {
    SAcc   = 10'b0000000001,
    SMul1  = 10'b0000000010,
    SMul2  = 10'b0000000100,
    SMul3  = 10'b0000001000,
    SDiv1  = 10'b0000010000,
    SSqrt  = 10'b0000100000,
    SMul4  = 10'b0001000000,
    SMul5  = 10'b0010000000,
    SDiv2  = 10'b0100000000,
    SOut   = 10'b1000000000
  } state_e;

  localparam logic [CntW-1:0] Cap = CntW'(1) << MaxVoxLog2;
  localparam logic [7:0] DivSteps = 8'd128;

  state_e st_q, st_d;
  logic mode_q;
  logic signed [SsW-1:0] ss_q, ss_d;
  logic [CntW-1:0] sn_q, sn_d, nn_q, nn_d;
  logic signed [NsW-1:0] ns_q, ns_d;
  logic [NqW-1:0] nq_q, nq_d;
  logic [127:0] t_q, t_d, x_q, x_d;
  logic [63:0] den_q, den_d, rem_q, rem_d, r_q, r_d;
  logic [66:0] sr_q, sr_d;
  logic [7:0] cnt_q, cnt_d;
  logic [31:0] snr_q, snr_d;
  status_e stat_q, stat_d;
  logic mstart;
  logic [63:0] ma, mb;
  logic mdone;
  logic [127:0] mp;

  snr_mul u_mul (
    .clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb), .done_o(mdone), .p_o(mp)
  );

  logic signed [16:0] smp;
  logic take;
  logic [16:0] smag;
  logic [33:0] sq;
  logic [63:0] nsmag, ssmag;
  logic [64:0] rsh, rsub;
  logic [66:0] srsh, strial;

  always_comb begin
    smp = mode_q ? (17'(pixel_i) - 17'(second_pixel_i)) : 17'(pixel_i);
    take = mode_q | noise_mask_i;
    smag = smp[16] ? 17'(-smp) : smp;
    sq = 34'(smag) * 34'(smag);
    nsmag = ns_q[NsW-1] ? 64'(-ns_q) : 64'(ns_q);
    ssmag = ss_q[SsW-1] ? 64'(-ss_q) : 64'(ss_q);
    rsh = {rem_q, x_q[127]};
    rsub = rsh - {1'b0, den_q};
    srsh = {sr_q[64:0], x_q[127:126]};
    strial = {1'b0, r_q, 2'b01};
  end

  always_comb begin
    st_d = st_q; ss_d = ss_q; sn_d = sn_q; ns_d = ns_q; nq_d = nq_q; nn_d = nn_q;
    t_d = t_q; x_d = x_q; den_d = den_q; rem_d = rem_q; r_d = r_q; cnt_d = cnt_q;
    sr_d = sr_q;
    snr_d = snr_q; stat_d = stat_q;
    mstart = 1'b0; ma = '0; mb = '0;
    case (st_q)
      SAcc: begin
        if (in_valid_i) begin
          if (signal_mask_i && sn_q < Cap) begin
            ss_d = ss_q + SsW'(pixel_i);
            sn_d = sn_q + 1'b1;
          end
          if (take && nn_q < Cap) begin
            ns_d = ns_q + NsW'(smp);
            nq_d = nq_q + NqW'(sq);
            nn_d = nn_q + 1'b1;
          end
          if (last_i) st_d = SMul1;
        end
      end
      SMul1: begin
        snr_d = '0;
        if (sn_q == '0) begin
          stat_d = StNoSignal; st_d = SOut;
        end else if (nn_q < CntW'(2)) begin
          stat_d = StFewNoise; st_d = SOut;
        end else begin
          mstart = 1'b1; ma = 64'(nn_q); mb = 64'(nq_q); st_d = SMul2;
        end
      end
      SMul2: if (mdone) begin
        t_d = mp; mstart = 1'b1; ma = nsmag; mb = nsmag; st_d = SMul3;
      end
      SMul3: if (mdone) begin
        t_d = t_q - mp;
        mstart = 1'b1; ma = 64'(nn_q); mb = 64'(nn_q - 1'b1);
        st_d = SDiv1;
        cnt_d = '0;
      end
      SDiv1: begin
        if (mdone) begin
          if (t_q == '0) begin
            stat_d = StZeroVar; st_d = SOut;
          end else begin
            den_d = mp[63:0]; x_d = {t_q[95:0], 32'd0}; rem_d = '0; cnt_d = DivSteps;
          end
        end else if (cnt_q != '0) begin
          if (!rsub[64]) rem_d = rsub[63:0];
          else rem_d = rsh[63:0];
          x_d = {x_q[126:0], ~rsub[64]};
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == 8'd1) begin
            st_d = SSqrt; r_d = '0; sr_d = '0; cnt_d = 8'd63;
          end
        end
      end
      SSqrt: begin
        x_d = {x_q[125:0], 2'b00};
        if (srsh >= strial) begin
          sr_d = srsh - strial; r_d = {r_q[62:0], 1'b1};
        end else begin
          sr_d = srsh; r_d = {r_q[62:0], 1'b0};
        end
        if (cnt_q == '0) begin
          st_d = SMul4;
          if (r_d == '0) begin
            stat_d = StZeroVar; st_d = SOut;
          end else begin
            mstart = 1'b1; ma = ssmag; mb = mode_q ? 64'(KDiff) : 64'(KRegion);
          end
        end else cnt_d = cnt_q - 1'b1;
      end
      SMul4: if (mdone) begin
        t_d = {mp[111:0], 16'd0};
        mstart = 1'b1; ma = 64'(sn_q); mb = r_q; st_d = SMul5;
      end
      SMul5: if (mdone) begin
        den_d = mp[63:0]; x_d = t_q; rem_d = '0; cnt_d = DivSteps; st_d = SDiv2;
      end
      SDiv2: begin
        if (!rsub[64]) rem_d = rsub[63:0];
        else rem_d = rsh[63:0];
        x_d = {x_q[126:0], ~rsub[64]};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == 8'd1) begin
          st_d = SOut;
          if (ss_q[SsW-1]) begin
            if (x_d[127:32] != '0 || x_d[31:0] > 32'h80000000) begin
              snr_d = 32'h80000000; stat_d = StSat;
            end else begin
              snr_d = 32'(-x_d[31:0]); stat_d = StOk;
            end
          end else if (x_d[127:31] != '0) begin
            snr_d = 32'h7fffffff; stat_d = StSat;
          end else begin
            snr_d = x_d[31:0]; stat_d = StOk;
          end
        end
      end
      SOut: begin
        if (out_ready_i) begin
          st_d = SAcc;
          ss_d = '0; sn_d = '0; ns_d = '0; nq_d = '0; nn_d = '0;
        end
      end
      default: st_d = SAcc;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SAcc; mode_q <= 1'b0;
      ss_q <= '0; sn_q <= '0; ns_q <= '0; nq_q <= '0; nn_q <= '0;
      cnt_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      ss_q <= ss_d; sn_q <= sn_d; ns_q <= ns_d; nq_q <= nq_d; nn_q <= nn_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d; x_q <= x_d; den_q <= den_d; rem_q <= rem_d; r_q <= r_d;
    sr_q <= sr_d;
    snr_q <= snr_d; stat_q <= stat_d;
  end

  assign in_ready_o = (st_q == SAcc);
  assign out_valid_o = (st_q == SOut);
  assign snr_o = snr_q;
  assign status_o = stat_q;
endmodule

// File: rtl/snr_mul.sv
// snr_mul: 64x64-bit shift-add multiplier, 128-bit product, one bit per cycle
// depends on snr_pkg
module snr_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] p_o
);
  import snr_pkg::*;
  logic [127:0] acc_q, acc_d, a_q, a_d;
  logic [63:0] b_q, b_d;
  logic busy_q, busy_d, done_q, done_d;

  always_comb begin
    acc_d = acc_q;
    a_d = a_q;
    b_d = b_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = '0;
      a_d = {64'd0, a_i};
      b_d = b_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        if (b_q[0]) acc_d = acc_q + a_q;
        a_d = {a_q[126:0], 1'b0};
        b_d = {1'b0, b_q[63:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign p_o = acc_q;
endmodule
